// File: hdl/cefd_pkg.sv
// ----------------------------------------------------------------------------
// cefd_pkg
// Shared types, constants and functions of the frame deframer.
// ----------------------------------------------------------------------------
package cefd_pkg;

    localparam logic [31:0] CRC_POLY         = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
    localparam logic [47:0] LOCAL_ADDR_RESET = 48'h0002_0406_080A;

    localparam int unsigned TDATA_W = 56;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DEST     = 3'd1;
    localparam logic [2:0] ST_OWN_SRC  = 3'd2;
    localparam logic [2:0] ST_LENGTH   = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;

    localparam logic [15:0] POS_SRC      = 16'd6;
    localparam logic [15:0] POS_LEN_HI   = 16'd12;
    localparam logic [15:0] POS_LEN_LO   = 16'd13;
    localparam logic [15:0] POS_MCAST    = 16'd14;
    localparam logic [15:0] POS_CTRL_HI  = 16'd14;
    localparam logic [15:0] POS_CTRL_LO  = 16'd15;
    localparam logic [15:0] POS_SER_HI   = 16'd16;
    localparam logic [15:0] POS_SER_LO   = 16'd17;
    localparam logic [15:0] POS_PAYLOAD  = 16'd18;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic        multicast;
        logic [6:0]  group_number;
        logic        no_multicast;
        logic        answer;
        logic        read_flag;
        logic        fifo_select;
        logic [11:0] target_address;
        logic [3:0]  serial_number;
        logic [11:0] payload_length;
    } t_result;

    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] local_byte(input logic [47:0] addr, input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = addr[47:40];
            3'd1:    r = addr[39:32];
            3'd2:    r = addr[31:24];
            3'd3:    r = addr[23:16];
            3'd4:    r = addr[15:8];
            3'd5:    r = addr[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/custom_ethernet_frame_deframer.sv
// ----------------------------------------------------------------------------
// custom_ethernet_frame_deframer
// Frame receiver: address, length and crc-32 checks, header parse and
// payload byte streaming with one status item per frame.
//
// channel   direction  tdata                      tuser / tlast
// s_axis    in         rx_byte                    tlast = end_of_frame
// m_axis    out        payload byte / status      tuser = is_status
// cfg       in         local_address (48 bits)    write enable only
//
// one byte per cycle sustained while m_axis is not stalled; a result goes
// from its input transfer through the input register, then the result register,
// with the bytewise crc update between them. reset clears all frame state and
// loads the default local address. when m_axis_tready is low the result register
// holds and s_axis_tready falls once the input register is full as well.
// ----------------------------------------------------------------------------
module custom_ethernet_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte, status, multicast, group_number, no_multicast, answer,
    // read_flag, fifo_select, target_address, serial_number, payload_length
    output logic [cefd_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tuser,   // is_status
    input  logic        i_cfg_wr_en,
    input  logic [47:0] i_cfg_wr_data
);

    cefd_pkg::t_in_item w_s_item;
    cefd_pkg::t_in_item w_item;
    cefd_pkg::t_result  w_res;
    cefd_pkg::t_result  w_out;
    logic               w_in_valid;
    logic               w_res_valid;
    logic               w_out_free;
    logic               w_fire;

    assign w_s_item.rx_byte      = s_axis_tdata;
    assign w_s_item.end_of_frame = s_axis_tlast;
    assign w_fire                = w_in_valid && w_out_free;

    cefd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_s_item),
        .i_advance (w_fire),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    cefd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_fire),
        .i_item        (w_item),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    cefd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_fire),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_free      (w_out_free),
        .o_res       (w_out)
    );

    assign m_axis_tuser = w_out.is_status;
    assign m_axis_tdata = {5'd0,
                           w_out.payload_length,
                           w_out.serial_number,
                           w_out.target_address,
                           w_out.fifo_select,
                           w_out.read_flag,
                           w_out.answer,
                           w_out.no_multicast,
                           w_out.group_number,
                           w_out.multicast,
                           w_out.status,
                           w_out.data_byte};

    a_ready_low_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_in_valid)
        else $error("input stage stalled while empty");

    a_fire_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> (!m_axis_tvalid || m_axis_tready))
        else $error("item processed while result register blocked");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[55:8] == 48'd0))
        else $error("payload item carries header or status bits");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser && m_axis_tdata[10:8] != cefd_pkg::ST_OK)
        |-> (m_axis_tdata[55:11] == 45'd0 && m_axis_tdata[7:0] == 8'd0))
        else $error("failed frame status carries header fields");

endmodule

// File: hdl/cefd_in_reg.sv
// ----------------------------------------------------------------------------
// cefd_in_reg
// Input register stage holding one received byte until it is processed.
// ----------------------------------------------------------------------------
module cefd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cefd_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output cefd_pkg::t_in_item o_item
);

    logic               r_valid;
    cefd_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hdl/cefd_parser.sv
// ----------------------------------------------------------------------------
// cefd_parser
// Per-frame header parse, address and length checks, crc and payload select.
// ----------------------------------------------------------------------------
module cefd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [47:0]        i_cfg_wr_data,
    input  logic               i_fire,
    input  cefd_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output cefd_pkg::t_result  o_res
);

    logic [47:0] r_local_addr;
    logic [15:0] r_byte_pos, n_byte_pos;
    logic [31:0] r_crc, n_crc;
    logic [7:0]  r_tail [4];
    logic [7:0]  n_tail [4];
    logic        r_dest_mis, n_dest_mis;
    logic        r_src_local, n_src_local;
    logic [15:0] r_len_word, n_len_word;
    logic        r_mc_seen, n_mc_seen;
    logic [6:0]  r_group, n_group;
    logic [15:0] r_ctrl, n_ctrl;
    logic [15:0] r_serlen, n_serlen;

    logic [7:0]  w_b;
    logic [15:0] w_p;
    logic [15:0] w_m;
    logic [15:0] w_start;
    logic [15:0] w_offset;
    logic [16:0] w_count;
    logic [31:0] w_trailer;
    logic [2:0]  w_status;
    logic [2:0]  w_src_idx;

    assign w_b       = i_item.rx_byte;
    assign w_p       = r_byte_pos;
    assign w_m       = {15'd0, r_mc_seen};
    assign w_src_idx = 3'(w_p - cefd_pkg::POS_SRC);

    always_comb begin
        n_crc       = (w_p >= 16'd4) ? cefd_pkg::crc_feed(r_crc, r_tail[0]) : r_crc;
        n_tail[0]   = r_tail[1];
        n_tail[1]   = r_tail[2];
        n_tail[2]   = r_tail[3];
        n_tail[3]   = w_b;
        n_dest_mis  = r_dest_mis;
        n_src_local = r_src_local;
        n_len_word  = r_len_word;
        n_mc_seen   = r_mc_seen;
        n_group     = r_group;
        n_ctrl      = r_ctrl;
        n_serlen    = r_serlen;

        if (w_p < cefd_pkg::POS_SRC) begin
            if (w_b != cefd_pkg::local_byte(r_local_addr, w_p[2:0])) begin
                n_dest_mis = 1'b1;
            end
        end else if (w_p < cefd_pkg::POS_LEN_HI) begin
            if (w_b != cefd_pkg::local_byte(r_local_addr, w_src_idx)) begin
                n_src_local = 1'b0;
            end
        end else if (w_p == cefd_pkg::POS_LEN_HI) begin
            n_len_word = {w_b, 8'h00};
        end else if (w_p == cefd_pkg::POS_LEN_LO) begin
            n_len_word = {r_len_word[15:8], w_b};
        end else if (w_p == cefd_pkg::POS_MCAST && w_b[7]) begin
            n_mc_seen = 1'b1;
            n_group   = w_b[6:0];
        end else if (w_p == cefd_pkg::POS_CTRL_HI + w_m) begin
            n_ctrl = {w_b, 8'h00};
        end else if (w_p == cefd_pkg::POS_CTRL_LO + w_m) begin
            n_ctrl = {r_ctrl[15:8], w_b};
        end else if (w_p == cefd_pkg::POS_SER_HI + w_m) begin
            n_serlen = {w_b, 8'h00};
        end else if (w_p == cefd_pkg::POS_SER_LO + w_m) begin
            n_serlen = {r_serlen[15:8], w_b};
        end

        n_byte_pos = (w_p == cefd_pkg::POS_MAX) ? w_p : w_p + 16'd1;
    end

    assign w_start   = cefd_pkg::POS_PAYLOAD + {15'd0, n_mc_seen};
    assign w_offset  = w_p - w_start;
    assign w_count   = {1'b0, w_p} + 17'd1;
    assign w_trailer = {n_tail[0], n_tail[1], n_tail[2], n_tail[3]};

    always_comb begin
        if (n_dest_mis) begin
            w_status = cefd_pkg::ST_DEST;
        end else if (w_count >= 17'd12 && n_src_local) begin
            w_status = cefd_pkg::ST_OWN_SRC;
        end else if (w_count < 17'd14 || {1'b0, n_len_word} != w_count) begin
            w_status = cefd_pkg::ST_LENGTH;
        end else if ((n_crc ^ cefd_pkg::CRC_INIT) != w_trailer) begin
            w_status = cefd_pkg::ST_CRC;
        end else begin
            w_status = cefd_pkg::ST_OK;
        end
    end

    always_comb begin
        o_res = '0;
        if (!i_item.end_of_frame) begin
            o_res_valid     = (w_p >= w_start) && (w_offset < {4'd0, n_serlen[11:0]});
            o_res.data_byte = w_b;
        end else begin
            o_res_valid     = 1'b1;
            o_res.is_status = 1'b1;
            o_res.status    = w_status;
            if (w_status == cefd_pkg::ST_OK) begin
                o_res.multicast      = n_mc_seen;
                o_res.group_number   = n_mc_seen ? n_group : 7'd0;
                o_res.no_multicast   = n_ctrl[15];
                o_res.answer         = n_ctrl[14];
                o_res.read_flag      = n_ctrl[13];
                o_res.fifo_select    = n_ctrl[12];
                o_res.target_address = n_ctrl[11:0];
                o_res.serial_number  = n_serlen[15:12];
                o_res.payload_length = n_serlen[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= cefd_pkg::LOCAL_ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_local_addr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.end_of_frame)) begin
            r_byte_pos  <= '0;
            r_crc       <= cefd_pkg::CRC_INIT;
            r_tail      <= '{default: 8'h00};
            r_dest_mis  <= 1'b0;
            r_src_local <= 1'b1;
            r_len_word  <= '0;
            r_mc_seen   <= 1'b0;
            r_group     <= '0;
            r_ctrl      <= '0;
            r_serlen    <= '0;
        end else if (i_fire) begin
            r_byte_pos  <= n_byte_pos;
            r_crc       <= n_crc;
            r_tail      <= n_tail;
            r_dest_mis  <= n_dest_mis;
            r_src_local <= n_src_local;
            r_len_word  <= n_len_word;
            r_mc_seen   <= n_mc_seen;
            r_group     <= n_group;
            r_ctrl      <= n_ctrl;
            r_serlen    <= n_serlen;
        end
    end

endmodule

// File: hdl/cefd_out_reg.sv
// ----------------------------------------------------------------------------
// cefd_out_reg
// Result register holding one payload or status item until it is taken.
// ----------------------------------------------------------------------------
module cefd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  cefd_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output cefd_pkg::t_result o_res
);

    logic              r_valid;
    cefd_pkg::t_result r_res;

    assign o_valid = r_valid;
    assign o_free  = !r_valid || i_ready;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule
